// ===== sv/atilt_pkg.sv =====
// shared types, widths and constants for the accelerometer tilt angle block
// depends on nothing; every other file imports it
package atilt_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 28;

  localparam int AXIS_W  = 16;
  localparam int DIV_BITS = 24;                  // magnitude of (axis - low) * 180
  localparam int MAP_W   = DIV_BITS + 1;         // signed mapped axis value
  localparam int VEC_W   = 30;                   // normalized magnitudes, top at bit 29
  localparam int XY_W    = VEC_W + 4;
  localparam int Z_W     = ANGLE_FRAC_BITS + 9;  // signed angle accumulator
  localparam int ANG_W   = ANGLE_FRAC_BITS + 9;  // unsigned angle, 0..360 degrees
  localparam int HUND_W  = ANGLE_FRAC_BITS + 16;
  localparam int OUT_W   = 16;
  localparam int NORM_STEPS = 5;

  localparam longint unsigned NANO_PER_DEG = 64'd1000000000;

  localparam logic [AXIS_W-1:0] SPAN_LOW_RESET  = 16'd265;
  localparam logic [AXIS_W-1:0] SPAN_HIGH_RESET = 16'd402;

  localparam logic [ANG_W-1:0] DEG_90  = ANG_W'(64'd90  << ANGLE_FRAC_BITS);
  localparam logic [ANG_W-1:0] DEG_180 = ANG_W'(64'd180 << ANGLE_FRAC_BITS);
  localparam logic [ANG_W-1:0] DEG_360 = ANG_W'(64'd360 << ANGLE_FRAC_BITS);

  localparam logic [OUT_W-1:0] HUND_90  = 16'd9000;
  localparam logic [OUT_W-1:0] HUND_180 = 16'd18000;
  localparam logic [OUT_W-1:0] HUND_270 = 16'd27000;
  localparam logic [OUT_W-1:0] HUND_360 = 16'd36000;

  typedef enum logic [1:0] {
    REG_SPAN_LOW  = 2'd0,
    REG_SPAN_HIGH = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
  } accel_t;

  typedef struct packed {
    logic [OUT_W-1:0] angle_about_x;
    logic [OUT_W-1:0] angle_about_y;
    logic [OUT_W-1:0] angle_about_z;
    logic             span_error;
  } angles_t;

  // side information that rides along the atan2 pipeline
  typedef struct packed {
    logic             special;
    logic [OUT_W-1:0] special_val;
    logic             q_neg;
    logic             p_neg;
  } side_t;

  // atan(2^-i) in units of 1e-9 degree
  localparam longint unsigned ATAN_NANO_DEG [CORDIC_STEPS] = '{
    64'd45000000000, 64'd26565051177, 64'd14036243468, 64'd7125016349,
    64'd3576334375,  64'd1789910608,  64'd895173710,   64'd447614171,
    64'd223810500,   64'd111905677,   64'd55952892,    64'd27976453,
    64'd13988227,    64'd6994114,     64'd3497057,     64'd1748528,
    64'd874264,      64'd437132,      64'd218566,      64'd109283,
    64'd54642,       64'd27321,       64'd13660,       64'd6830,
    64'd3415,        64'd1708,        64'd854,         64'd427
  };

  function automatic logic signed [Z_W-1:0] atan_step(input int i);
    longint unsigned v;
    v = (ATAN_NANO_DEG[i] * (64'd1 << ANGLE_FRAC_BITS) + NANO_PER_DEG / 2) / NANO_PER_DEG;
    return Z_W'(v);
  endfunction

endpackage

// ===== sv/atilt_if.sv =====
// valid/ready stream interfaces for samples and angle results
// depends on atilt_pkg
interface atilt_in_if import atilt_pkg::*; ;
  logic   valid;
  logic   ready;
  accel_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface atilt_out_if import atilt_pkg::*; ;
  logic    valid;
  logic    ready;
  angles_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/atilt_scale.sv =====
// maps one raw axis from span_low..span_high onto -90..90: scale by 180, then a radix-2 divider pipeline
// depends on atilt_pkg
module atilt_scale import atilt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [AXIS_W-1:0] axis,
  input  logic signed [AXIS_W-1:0] span_low,
  input  logic        [AXIS_W-1:0] span_diff,
  output logic                     out_valid,
  output logic signed [MAP_W-1:0]  mapped
);

  localparam logic signed [MAP_W-1:0] SCALE  = MAP_W'(180);
  localparam logic signed [MAP_W-1:0] OFFSET = MAP_W'(90);

  logic signed [AXIS_W:0]   diff;
  logic signed [MAP_W-1:0]  diff_w;
  logic signed [MAP_W-1:0]  prod;
  logic        [MAP_W-1:0]  prod_abs;

  logic                     dv  [DIV_BITS+1];
  logic                     neg [DIV_BITS+1];
  logic [DIV_BITS-1:0]      num [DIV_BITS+1];
  logic [DIV_BITS-1:0]      quo [DIV_BITS+1];
  logic [AXIS_W-1:0]        rem [DIV_BITS+1];

  logic signed [MAP_W-1:0]  quo_s;

  always_comb begin
    diff     = {axis[AXIS_W-1], axis} - {span_low[AXIS_W-1], span_low};
    diff_w   = {{(MAP_W-AXIS_W-1){diff[AXIS_W]}}, diff};
    prod     = diff_w * SCALE;
    prod_abs = prod[MAP_W-1] ? MAP_W'(-prod) : MAP_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= prod[MAP_W-1];
      num[0] <= prod_abs[DIV_BITS-1:0];
      quo[0] <= '0;
      rem[0] <= '0;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    localparam int BIT = DIV_BITS - 1 - k;
    logic [AXIS_W:0] trial;
    logic            ge;

    always_comb begin
      trial = {rem[k], num[k][BIT]};
      ge    = trial >= {1'b0, span_diff};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg[k+1] <= neg[k];
        num[k+1] <= num[k];
        quo[k+1] <= quo[k] | (DIV_BITS'(ge) << BIT);
        rem[k+1] <= ge ? AXIS_W'(trial - {1'b0, span_diff}) : trial[AXIS_W-1:0];
      end
    end
  end

  always_comb begin
    quo_s = {1'b0, quo[DIV_BITS]};
    if (neg[DIV_BITS]) begin
      quo_s = -quo_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mapped <= quo_s - OFFSET;
    end
  end

endmodule

// ===== sv/atilt_atan2.sv =====
// pipelined direction of (q, p) in hundredths of a degree:
// sign split, normalize, cordic vectoring, quadrant fix and rounding
// depends on atilt_pkg
module atilt_atan2 import atilt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [MAP_W-1:0] p,
  input  logic signed [MAP_W-1:0] q,
  output logic                    out_valid,
  output logic [OUT_W-1:0]        angle
);

  logic                 nv [NORM_STEPS+1];
  logic [VEC_W-1:0]     nx [NORM_STEPS+1];
  logic [VEC_W-1:0]     ny [NORM_STEPS+1];
  side_t                ns [NORM_STEPS+1];

  logic                 cv [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] cx [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] cy [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  cz [CORDIC_STEPS+1];
  side_t                cs [CORDIC_STEPS+1];

  side_t                front_side;
  logic [MAP_W-1:0]     abs_q;
  logic [MAP_W-1:0]     abs_p;

  // front: signs, magnitudes and the on-axis cases
  always_comb begin
    abs_q = q[MAP_W-1] ? MAP_W'(-q) : MAP_W'(q);
    abs_p = p[MAP_W-1] ? MAP_W'(-p) : MAP_W'(p);
    front_side.q_neg       = q[MAP_W-1];
    front_side.p_neg       = p[MAP_W-1];
    front_side.special     = 1'b0;
    front_side.special_val = HUND_180;
    if (p == '0) begin
      front_side.special     = 1'b1;
      front_side.special_val = (q[MAP_W-1] || q == '0) ? HUND_180 : HUND_360;
    end else if (q == '0) begin
      front_side.special     = 1'b1;
      front_side.special_val = p[MAP_W-1] ? HUND_270 : HUND_90;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nv[0] <= 1'b0;
    end else if (en) begin
      nv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx[0] <= VEC_W'(abs_q[DIV_BITS-1:0]);
      ny[0] <= VEC_W'(abs_p[DIV_BITS-1:0]);
      ns[0] <= front_side;
    end
  end

  // shift both magnitudes left until the larger one reaches bit VEC_W-1
  for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
    localparam int SH  = 16 >> g;
    localparam int LIM = VEC_W - SH;
    logic small_both;

    assign small_both = (nx[g][VEC_W-1:LIM] == '0) && (ny[g][VEC_W-1:LIM] == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        nv[g+1] <= 1'b0;
      end else if (en) begin
        nv[g+1] <= nv[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nx[g+1] <= small_both ? (nx[g] << SH) : nx[g];
        ny[g+1] <= small_both ? (ny[g] << SH) : ny[g];
        ns[g+1] <= ns[g];
      end
    end
  end

  assign cv[0] = nv[NORM_STEPS];
  assign cx[0] = XY_W'(nx[NORM_STEPS]);
  assign cy[0] = XY_W'(ny[NORM_STEPS]);
  assign cz[0] = '0;
  assign cs[0] = ns[NORM_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [Z_W-1:0] STEP = atan_step(i);
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs[i+1] <= cs[i];
        if (!cy[i][XY_W-1]) begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + STEP;
        end else begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - STEP;
        end
      end
    end
  end

  // clamp to the first quadrant, then place in the right quadrant
  logic [ANG_W-1:0] base;
  logic [ANG_W-1:0] quad_ang;
  logic             fv;
  logic [ANG_W-1:0] fang;
  side_t            fside;

  always_comb begin
    if (cz[CORDIC_STEPS][Z_W-1]) begin
      base = '0;
    end else if (ANG_W'(cz[CORDIC_STEPS]) > DEG_90) begin
      base = DEG_90;
    end else begin
      base = ANG_W'(cz[CORDIC_STEPS]);
    end
    case ({cs[CORDIC_STEPS].q_neg, cs[CORDIC_STEPS].p_neg})
      2'b00:   quad_ang = base;
      2'b10:   quad_ang = DEG_180 - base;
      2'b11:   quad_ang = DEG_180 + base;
      default: quad_ang = DEG_360 - base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fang  <= quad_ang;
      fside <= cs[CORDIC_STEPS];
    end
  end

  // degrees to rounded hundredths
  logic [HUND_W-1:0] hund;

  assign hund = HUND_W'(fang) * HUND_W'(100) + HUND_W'(64'd1 << (ANGLE_FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= fside.special ? fside.special_val
                             : hund[ANGLE_FRAC_BITS +: OUT_W];
    end
  end

endmodule

// ===== sv/accel_tilt_angles.sv =====
// accelerometer tilt angles: each sample passes the axis mapping divider, then the atan2 pipeline,
// one sample per cycle while the output skid is empty
// fully pipelined: a one-bit-per-stage divider and one cordic stage per step
// a one-entry output skid parks a result the sink refuses; the pipeline and the sample
// input stall while it is full and restart the cycle after it drains
// synchronous reset clears the pipeline valid bits and the skid, and loads span_low = 265, span_high = 402
module accel_tilt_angles import atilt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [AXIS_W-1:0]  cfg_data,
  atilt_in_if.sink           sample,
  atilt_out_if.source        result
);

  logic [AXIS_W-1:0] span_low;
  logic [AXIS_W-1:0] span_high;
  logic [AXIS_W-1:0] span_diff;
  logic              span_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_low  <= SPAN_LOW_RESET;
      span_high <= SPAN_HIGH_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SPAN_LOW:  span_low  <= cfg_data;
        REG_SPAN_HIGH: span_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign span_diff = span_high - span_low;
  assign span_bad  = $signed(span_high) <= $signed(span_low);

  logic en;
  logic skid_valid;
  angles_t skid;

  assign en           = !skid_valid;
  assign sample.ready = en;

  logic                    mx_v, my_v, mz_v;
  logic signed [MAP_W-1:0] mx, my, mz;

  atilt_scale u_scale_x (
    .clk, .rst, .en, .in_valid(sample.valid), .axis(sample.data.accel_x),
    .span_low($signed(span_low)), .span_diff, .out_valid(mx_v), .mapped(mx)
  );
  atilt_scale u_scale_y (
    .clk, .rst, .en, .in_valid(sample.valid), .axis(sample.data.accel_y),
    .span_low($signed(span_low)), .span_diff, .out_valid(my_v), .mapped(my)
  );
  atilt_scale u_scale_z (
    .clk, .rst, .en, .in_valid(sample.valid), .axis(sample.data.accel_z),
    .span_low($signed(span_low)), .span_diff, .out_valid(mz_v), .mapped(mz)
  );

  logic             ax_v, ay_v, az_v;
  logic [OUT_W-1:0] ang_x, ang_y, ang_z;

  atilt_atan2 u_atan_x (
    .clk, .rst, .en, .in_valid(mx_v), .p(my), .q(mz), .out_valid(ax_v), .angle(ang_x)
  );
  atilt_atan2 u_atan_y (
    .clk, .rst, .en, .in_valid(my_v), .p(mx), .q(mz), .out_valid(ay_v), .angle(ang_y)
  );
  atilt_atan2 u_atan_z (
    .clk, .rst, .en, .in_valid(mz_v), .p(my), .q(mx), .out_valid(az_v), .angle(ang_z)
  );

  logic    res_valid;
  angles_t res;

  // all three lanes run in lockstep
  assign res_valid = ax_v && ay_v && az_v;

  always_comb begin
    res.span_error    = span_bad;
    res.angle_about_x = span_bad ? '0 : ang_x;
    res.angle_about_y = span_bad ? '0 : ang_y;
    res.angle_about_z = span_bad ? '0 : ang_z;
  end

  // park the result when the sink stalls, freezing the pipeline behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid && !result.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid <= res;
    end
  end

  assign result.valid = skid_valid || res_valid;
  assign result.data  = skid_valid ? skid : res;

endmodule

// ===== dv/tb_accel_tilt_angles.sv =====
// self-checking testbench for accel_tilt_angles: directed table, then random samples
// under several span settings; depends on atilt_pkg, atilt_if and the rtl top
module tb_accel_tilt_angles;
  import atilt_pkg::*;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;
  typedef struct {
    row_kind_t  kind;
    logic [1:0] idx;
    logic [15:0] val;
    accel_t     acc;
    bit         typed;
    angles_t    want;
  } row_t;

  localparam logic [1:0] REG_UNUSED = 2'd2;
  localparam logic [1:0] REG_SPARE  = 2'd3;
  localparam int DRAIN_CYCLES = 70;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [1:0] cfg_index = '0;
  logic [AXIS_W-1:0] cfg_data = '0;

  atilt_in_if  sample_if ();
  atilt_out_if result_if ();

  accel_tilt_angles u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .sample(sample_if), .result(result_if)
  );

  always #5 clk = ~clk;

  logic [15:0] span_lo_q = SPAN_LOW_RESET;
  logic [15:0] span_hi_q = SPAN_HIGH_RESET;
  angles_t     pending_angles[$];
  int          errors = 0;
  int          results_seen = 0;
  int          bad_span_seen = 0;
  int          sink_hold = 0;
  bit          no_idle = 0;
  row_t        rows[$];

  function automatic longint map_axis(logic signed [15:0] a, longint lo, longint d);
    return ((longint'(a) - lo) * 180) / d - 90;
  endfunction

  // first-quadrant direction of (ax, ay) in degree fixed point
  function automatic longint quadrant_angle(longint ax, longint ay);
    longint x, y, z, dx, dy, big, step;
    int n;
    z = 0;
    n = 0;
    big = (ax > ay) ? ax : ay;
    while (big < (64'sd1 <<< 29) && n < 40) begin
      big = big <<< 1;
      n++;
    end
    x = ax <<< n;
    y = ay <<< n;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      step = longint'((ATAN_NANO_DEG[i] * (64'd1 << ANGLE_FRAC_BITS) + NANO_PER_DEG / 2)
                      / NANO_PER_DEG);
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += step;
      end else begin
        x -= dx; y += dy; z -= step;
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd90 <<< ANGLE_FRAC_BITS)) z = 64'sd90 <<< ANGLE_FRAC_BITS;
    return z;
  endfunction

  // direction of (q, p) in hundredths of a degree, [0, 360]
  function automatic logic [15:0] direction_hundredths(longint p, longint q);
    longint base, ang;
    if (p == 0 && q == 0) return HUND_180;
    if (p == 0) return (q > 0) ? HUND_360 : HUND_180;
    if (q == 0) return (p > 0) ? HUND_90 : HUND_270;
    base = quadrant_angle(q < 0 ? -q : q, p < 0 ? -p : p);
    if (q > 0 && p > 0) ang = base;
    else if (q < 0 && p > 0) ang = (64'sd180 <<< ANGLE_FRAC_BITS) - base;
    else if (q < 0) ang = (64'sd180 <<< ANGLE_FRAC_BITS) + base;
    else ang = (64'sd360 <<< ANGLE_FRAC_BITS) - base;
    return 16'((ang * 100 + (64'sd1 <<< (ANGLE_FRAC_BITS - 1))) >>> ANGLE_FRAC_BITS);
  endfunction

  function automatic angles_t tilt_of(accel_t s);
    angles_t r;
    longint lo, hi, mx, my, mz;
    lo = longint'($signed(span_lo_q));
    hi = longint'($signed(span_hi_q));
    r = '0;
    if (hi <= lo) begin
      r.span_error = 1'b1;
      return r;
    end
    mx = map_axis(s.accel_x, lo, hi - lo);
    my = map_axis(s.accel_y, lo, hi - lo);
    mz = map_axis(s.accel_z, lo, hi - lo);
    r.angle_about_x = direction_hundredths(my, mz);
    r.angle_about_y = direction_hundredths(mx, mz);
    r.angle_about_z = direction_hundredths(my, mx);
    return r;
  endfunction

  task automatic write_span(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_SPAN_LOW) span_lo_q = val;
    else if (idx == REG_SPAN_HIGH) span_hi_q = val;
  endtask

  // stop offering the last sample, then wait until nothing is in flight
  task automatic wait_drained();
    @(negedge clk);
    sample_if.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one sample transaction; the expectation is queued at acceptance
  task automatic send_sample(accel_t s, bit typed, angles_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk);
      sample_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sample_if.valid <= 1'b1;
    sample_if.data  <= s;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    pending_angles.push_back(typed ? want : tilt_of(s));
  endtask

  always @(negedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      result_if.ready <= 1'b0;
      sink_hold--;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    angles_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      results_seen++;
      if (result_if.data.span_error) bad_span_seen++;
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result_if.data);
        errors++;
      end else begin
        want = pending_angles.pop_front();
        if (want.angle_about_x !== result_if.data.angle_about_x) begin
          $display("%0t: angle_about_x expected %0d actual %0d", $time,
                   want.angle_about_x, result_if.data.angle_about_x);
          errors++;
        end
        if (want.angle_about_y !== result_if.data.angle_about_y) begin
          $display("%0t: angle_about_y expected %0d actual %0d", $time,
                   want.angle_about_y, result_if.data.angle_about_y);
          errors++;
        end
        if (want.angle_about_z !== result_if.data.angle_about_z) begin
          $display("%0t: angle_about_z expected %0d actual %0d", $time,
                   want.angle_about_z, result_if.data.angle_about_z);
          errors++;
        end
        if (want.span_error !== result_if.data.span_error) begin
          $display("%0t: span_error expected %0b actual %0b", $time,
                   want.span_error, result_if.data.span_error);
          errors++;
        end
      end
      sink_hold = no_idle ? 0 : $urandom_range(0, 19);
    end
  end

  function automatic row_t cfg_row(logic [1:0] idx, logic [15:0] val);
    row_t r;
    r = '{ROW_CFG, idx, val, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t smp_row(int x, int y, int z, bit typed, angles_t want);
    row_t r;
    accel_t s;
    s.accel_x = 16'(x);
    s.accel_y = 16'(y);
    s.accel_z = 16'(z);
    r = '{ROW_SAMPLE, 2'd0, 16'd0, s, typed, want};
    return r;
  endfunction

  function automatic logic [15:0] axis_draw(logic [15:0] lo, logic [15:0] hi);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6 && $signed(hi) > $signed(lo))
      return 16'($urandom_range(0, int'($signed(hi)) - int'($signed(lo))) + int'($signed(lo)));
    else if (pick < 8)
      return 16'($urandom);
    else if (pick == 8)
      return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    else
      return $urandom_range(0, 1) ? lo : hi;
  endfunction

  initial begin
    #20_000_000;
    $display("accel_tilt_angles test failed");
    $finish;
  end

  initial begin
    accel_t s;
    logic [15:0] lo, hi;
    int spread;
    sample_if.valid = 1'b0;
    sample_if.data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // with the reset span, 334 maps to 0, 402 to +90 and 265 to -90
    rows.push_back(smp_row(334, 334, 334, 1, '{HUND_180, HUND_180, HUND_180, 1'b0}));
    rows.push_back(smp_row(334, 334, 402, 1, '{HUND_360, HUND_360, HUND_180, 1'b0}));
    rows.push_back(smp_row(334, 334, 265, 1, '{HUND_180, HUND_180, HUND_180, 1'b0}));
    rows.push_back(smp_row(402, 334, 334, 1, '{HUND_180, HUND_90, HUND_360, 1'b0}));
    rows.push_back(smp_row(265, 334, 334, 1, '{HUND_180, HUND_270, HUND_180, 1'b0}));
    rows.push_back(smp_row(334, 402, 334, 1, '{HUND_90, HUND_180, HUND_90, 1'b0}));
    rows.push_back(smp_row(334, 265, 334, 1, '{HUND_270, HUND_180, HUND_270, 1'b0}));
    rows.push_back(smp_row(300, 380, 290, 0, '0));
    rows.push_back(smp_row(32767, -32768, 0, 0, '0));
    rows.push_back(smp_row(-32768, 32767, -1, 0, '0));
    rows.push_back(cfg_row(REG_UNUSED, 16'h8000));
    rows.push_back(cfg_row(REG_SPARE, 16'h7fff));
    rows.push_back(smp_row(402, 265, 300, 0, '0));
    rows.push_back(cfg_row(REG_SPAN_LOW, 16'd100));
    rows.push_back(cfg_row(REG_SPAN_HIGH, 16'd100));
    rows.push_back(smp_row(100, 0, -5, 1, '{16'd0, 16'd0, 16'd0, 1'b1}));
    rows.push_back(cfg_row(REG_SPAN_LOW, 16'h7fff));
    rows.push_back(cfg_row(REG_SPAN_HIGH, 16'h8000));
    rows.push_back(smp_row(32767, -32768, 1, 1, '{16'd0, 16'd0, 16'd0, 1'b1}));
    rows.push_back(cfg_row(REG_SPAN_LOW, 16'h8000));
    rows.push_back(cfg_row(REG_SPAN_HIGH, 16'h7fff));
    rows.push_back(smp_row(-32768, 32767, 0, 0, '0));
    rows.push_back(smp_row(32767, 32767, -32768, 0, '0));
    rows.push_back(smp_row(-1, 0, 12345, 0, '0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_span(rows[i].idx, rows[i].val);
      end else begin
        send_sample(rows[i].acc, rows[i].typed, rows[i].want);
      end
    end

    // random phases, each under its own span setting
    for (int ph = 0; ph < 12; ph++) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0: begin lo = 16'h8000; hi = 16'h7fff; end
        1: begin lo = 16'($urandom); hi = lo + 16'd1; end
        2: begin lo = 16'($urandom); hi = 16'($urandom); end
        default: begin
          spread = $urandom_range(1, 4000);
          lo = 16'($urandom_range(0, 60000) - 32768);
          hi = 16'(int'($signed(lo)) + spread);
          if ($signed(hi) <= $signed(lo)) hi = 16'h7fff;
        end
      endcase
      if (ph == 11) begin
        lo = SPAN_LOW_RESET;
        hi = SPAN_LOW_RESET;
      end
      write_span(REG_SPAN_LOW, lo);
      write_span(REG_SPAN_HIGH, hi);
      no_idle = (ph % 4 == 1);
      for (int k = 0; k < 120; k++) begin
        s.accel_x = axis_draw(span_lo_q, span_hi_q);
        s.accel_y = axis_draw(span_lo_q, span_hi_q);
        s.accel_z = axis_draw(span_lo_q, span_hi_q);
        if ($urandom_range(0, 15) == 0) s.accel_y = s.accel_x;
        send_sample(s, 1'b0, '0);
      end
    end
    @(negedge clk);
    sample_if.valid <= 1'b0;

    wait_drained();
    $display("covered %0d results (%0d with bad span) over 12 random span settings",
             results_seen, bad_span_seen);
    $display("plus a directed table of axis, extreme and register cases");
    if (errors == 0) begin
      $display("accel_tilt_angles test passed");
    end else begin
      $display("accel_tilt_angles test failed");
    end
    $finish;
  end
endmodule

// ===== accel_tilt_angles.f =====
sv/atilt_pkg.sv
sv/atilt_if.sv
sv/atilt_scale.sv
sv/atilt_atan2.sv
sv/accel_tilt_angles.sv
dv/tb_accel_tilt_angles.sv
